/* rtl/ole_pkg.sv */
// Shared types and codes of the ordered list engine.
package ole_pkg;

    typedef enum logic [2:0] {
        OP_FRONT  = 3'd0,
        OP_BACK   = 3'd1,
        OP_AFTER  = 3'd2,
        OP_SORTED = 3'd3,
        OP_REMOVE = 3'd4,
        OP_SEARCH = 3'd5,
        OP_DUMP   = 3'd6,
        OP_UNUSED = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic    start;
        logic    step;
        logic    use_input;
        logic    ins_front;
        logic    ins_w1;
        logic    succ_cur;
        logic    tgt_prev;
        logic    ins_w2;
        logic    unlink;
        logic    res_valid;
        status_t res_status;
        logic    res_val;
        logic    res_pos;
        logic    res_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic is_first;
        logic is_last;
        logic eq_value;
        logic eq_anchor;
        logic lt_value;
        logic le_value;
        op_t  op;
    } dp_stat_t;

endpackage

/* rtl/ole_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ole_ctrl.sv */
// Controller state machine of the ordered list engine.
module ole_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        operation,
    input  ole_pkg::dp_stat_t stat,
    output ole_pkg::ctrl_cmd_t cmd,
    output logic              busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_LINK = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        ole_pkg::op_t op_in;
        op_in      = ole_pkg::op_t'(operation);
        state_next = state_reg;
        cmd        = '0;
        cmd.res_status = ole_pkg::ST_DONE;
        cmd.res_last   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (op_in)
                        ole_pkg::OP_FRONT, ole_pkg::OP_BACK,
                        ole_pkg::OP_AFTER, ole_pkg::OP_SORTED:
                        begin
                            if (stat.full)
                            begin
                                cmd.res_valid  = 1'b1;
                                cmd.res_status = ole_pkg::ST_FULL;
                            end
                            else if (stat.empty || op_in == ole_pkg::OP_FRONT)
                            begin
                                cmd.ins_front = 1'b1;
                                cmd.use_input = 1'b1;
                                cmd.res_valid = 1'b1;
                            end
                            else
                            begin
                                cmd.start  = 1'b1;
                                state_next = S_WALK;
                            end
                        end
                        ole_pkg::OP_REMOVE, ole_pkg::OP_SEARCH, ole_pkg::OP_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.res_valid  = 1'b1;
                                cmd.res_status = ole_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.start  = 1'b1;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                unique case (stat.op)
                    ole_pkg::OP_BACK, ole_pkg::OP_AFTER:
                    begin
                        if (stat.is_last || (stat.op == ole_pkg::OP_AFTER && stat.eq_anchor))
                        begin
                            cmd.ins_w1 = 1'b1;
                            state_next = S_LINK;
                        end
                        else
                        begin
                            cmd.step = 1'b1;
                        end
                    end
                    ole_pkg::OP_SORTED:
                    begin
                        priority if (stat.is_first && stat.lt_value)
                        begin
                            cmd.ins_front = 1'b1;
                            cmd.res_valid = 1'b1;
                            state_next    = S_IDLE;
                        end
                        else if (!stat.is_first && stat.le_value)
                        begin
                            cmd.ins_w1   = 1'b1;
                            cmd.succ_cur = 1'b1;
                            cmd.tgt_prev = 1'b1;
                            state_next   = S_LINK;
                        end
                        else if (stat.is_last)
                        begin
                            cmd.ins_w1 = 1'b1;
                            state_next = S_LINK;
                        end
                        else
                        begin
                            cmd.step = 1'b1;
                        end
                    end
                    ole_pkg::OP_REMOVE, ole_pkg::OP_SEARCH:
                    begin
                        priority if (stat.eq_value)
                        begin
                            cmd.unlink    = (stat.op == ole_pkg::OP_REMOVE);
                            cmd.res_valid = 1'b1;
                            cmd.res_val   = (stat.op == ole_pkg::OP_REMOVE);
                            cmd.res_pos   = 1'b1;
                            state_next    = S_IDLE;
                        end
                        else if (stat.is_last)
                        begin
                            cmd.res_valid  = 1'b1;
                            cmd.res_status = ole_pkg::ST_NOT_FOUND;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.step = 1'b1;
                        end
                    end
                    ole_pkg::OP_DUMP:
                    begin
                        cmd.res_valid = 1'b1;
                        cmd.res_val   = 1'b1;
                        cmd.res_pos   = 1'b1;
                        cmd.res_last  = stat.is_last;
                        if (stat.is_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.step = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LINK:
            begin
                cmd.ins_w2    = 1'b1;
                cmd.res_valid = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ole_datapath.sv */
// Datapath of the ordered list engine: entry pool, list registers and result register.
module ole_datapath #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ole_pkg::ctrl_cmd_t cmd,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    input  logic signed [31:0] anchor,
    output ole_pkg::dp_stat_t  stat,
    output logic               strobe,
    output logic [1:0]         status,
    output logic signed [31:0] item_value,
    output logic [3:0]         position,
    output logic               last
);

    localparam int IDXW = $clog2(CAPACITY);
    localparam int CNTW = $clog2(CAPACITY + 1);

    logic [IDXW-1:0]        head_reg, head_next;
    logic [CNTW-1:0]        count_reg, count_next;
    logic [CAPACITY-1:0]    free_map_reg, free_map_next;
    logic [IDXW-1:0]        cur_reg, prev_reg, idx_reg, tgt_reg;
    logic [VALUE_WIDTH-1:0] val_reg, anc_reg;
    ole_pkg::op_t           op_reg;

    logic                   strobe_reg;
    ole_pkg::status_t       status_reg;
    logic signed [31:0]     item_value_reg;
    logic [3:0]             position_reg;
    logic                   last_reg;

    logic signed [63:0]     value_ext, anchor_ext, rd_ext;
    logic [VALUE_WIDTH-1:0] value_in, anchor_in;
    logic [VALUE_WIDTH-1:0] rd_val;
    logic [IDXW-1:0]        rd_link;
    logic [IDXW-1:0]        alloc;
    logic [IDXW-1:0]        raddr;
    logic                   val_we, link_we;
    logic [IDXW-1:0]        link_waddr, link_wdata;
    logic [VALUE_WIDTH-1:0] val_wdata;

    assign value_ext  = 64'(value);
    assign anchor_ext = 64'(anchor);
    assign value_in   = value_ext[VALUE_WIDTH-1:0];
    assign anchor_in  = anchor_ext[VALUE_WIDTH-1:0];
    assign rd_ext     = 64'($signed(rd_val));

    always_comb
    begin
        alloc = '0;
        for (int k = CAPACITY - 1; k >= 0; k--)
        begin
            if (free_map_reg[k])
            begin
                alloc = IDXW'(k);
            end
        end
    end

    assign raddr = cmd.step ? rd_link : head_reg;

    assign val_we    = cmd.ins_front || cmd.ins_w1;
    assign val_wdata = cmd.use_input ? value_in : val_reg;

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = alloc;
        link_wdata = head_reg;
        priority if (cmd.ins_front)
        begin
            link_we = 1'b1;
        end
        else if (cmd.ins_w1)
        begin
            link_we    = 1'b1;
            link_wdata = cmd.succ_cur ? cur_reg : rd_link;
        end
        else if (cmd.ins_w2)
        begin
            link_we    = 1'b1;
            link_waddr = tgt_reg;
            link_wdata = alloc;
        end
        else if (cmd.unlink && idx_reg != '0)
        begin
            link_we    = 1'b1;
            link_waddr = prev_reg;
            link_wdata = rd_link;
        end
    end

    ole_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (alloc),
        .wdata (val_wdata),
        .raddr (raddr),
        .rdata (rd_val)
    );

    ole_ram #(
        .WIDTH (IDXW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (raddr),
        .rdata (rd_link)
    );

    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        free_map_next = free_map_reg;
        if (cmd.ins_front || cmd.ins_w2)
        begin
            count_next    = count_reg + CNTW'(1);
            free_map_next = free_map_reg & ~(CAPACITY'(1) << alloc);
        end
        if (cmd.ins_front)
        begin
            head_next = alloc;
        end
        if (cmd.unlink)
        begin
            count_next    = count_reg - CNTW'(1);
            free_map_next = free_map_reg | (CAPACITY'(1) << cur_reg);
            if (idx_reg == '0)
            begin
                head_next = rd_link;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            free_map_reg <= '1;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            free_map_reg <= free_map_next;
            strobe_reg   <= cmd.res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cur_reg <= head_reg;
            idx_reg <= '0;
            val_reg <= value_in;
            anc_reg <= anchor_in;
            op_reg  <= ole_pkg::op_t'(operation);
        end
        else if (cmd.step)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= rd_link;
            idx_reg  <= idx_reg + IDXW'(1);
        end
        if (cmd.ins_w1)
        begin
            tgt_reg <= cmd.tgt_prev ? prev_reg : cur_reg;
        end
        status_reg     <= cmd.res_status;
        item_value_reg <= cmd.res_val ? rd_ext[31:0] : '0;
        position_reg   <= cmd.res_pos ? 4'(idx_reg) : '0;
        last_reg       <= cmd.res_last;
    end

    assign stat.full      = (count_reg == CNTW'(CAPACITY));
    assign stat.empty     = (count_reg == '0);
    assign stat.is_first  = (idx_reg == '0);
    assign stat.is_last   = ((CNTW'(idx_reg) + CNTW'(1)) == count_reg);
    assign stat.eq_value  = (rd_val == val_reg);
    assign stat.eq_anchor = (rd_val == anc_reg);
    assign stat.lt_value  = ($signed(val_reg) < $signed(rd_val));
    assign stat.le_value  = ($signed(val_reg) <= $signed(rd_val));
    assign stat.op        = op_reg;

    assign strobe     = strobe_reg;
    assign status     = status_reg;
    assign item_value = item_value_reg;
    assign position   = position_reg;
    assign last       = last_reg;

endmodule

/* rtl/ordered_list_engine.sv */
// Top level of the ordered list engine: bounded singly linked list of signed values.
// A full, empty or front insert gives its item in the cycle after start.
// Other items walk one entry per cycle, and an insert linked after an entry takes
// a further link state before its result; dump gives one item a cycle.
// Flow: one item in flight; start is taken again once busy is low; the receiver cannot
// stall. Reset: asynchronous, list empty.
module ordered_list_engine #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    input  logic signed [31:0] anchor,
    output logic               strobe,
    output logic [1:0]         status,
    output logic signed [31:0] item_value,
    output logic [3:0]         position,
    output logic               last
);

    ole_pkg::ctrl_cmd_t cmd;
    ole_pkg::dp_stat_t  stat;

    ole_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    ole_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .operation  (operation),
        .value      (value),
        .anchor     (anchor),
        .stat       (stat),
        .strobe     (strobe),
        .status     (status),
        .item_value (item_value),
        .position   (position),
        .last       (last)
    );

endmodule

/* rtl/ole_checker.sv */
// Port-level checker of the ordered list engine and its bind.
module ole_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [2:0]         operation,
    input logic               strobe,
    input logic [1:0]         status,
    input logic signed [31:0] item_value,
    input logic [3:0]         position,
    input logic               last
);

    a_fail_result_form: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status == ole_pkg::ST_NOT_FOUND || status == ole_pkg::ST_EMPTY
                   || status == ole_pkg::ST_FULL)
        |-> last && item_value == '0 && position == '0)
        else $error("failure result with payload or without last");

    a_dump_continues: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("dump stream broken before last item");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !start |=> !strobe)
        else $error("result without an item in flight");

    a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation == ole_pkg::OP_UNUSED |=> !strobe && !busy)
        else $error("unused operation produced activity");

endmodule

bind ordered_list_engine ole_checker u_checker (.*);
